[rtl/igemv_pkg.sv]
package igemv_pkg;

   // field widths fixed by the stream format
   localparam int ACT_W        = 32;
   localparam int SCALE_W      = 32;
   localparam int WEIGHT_W     = 8;
   localparam int WEIGHT_LANES = 8;
   localparam int WPACK_W      = WEIGHT_W * WEIGHT_LANES;
   localparam int ACC_W        = 32;
   localparam int OUT_LANES    = 8;
   localparam int QACT_W       = 8;
   localparam int PROD_W       = ACT_W + SCALE_W;

   // defaults and limits
   localparam int LANES_DEFAULT = 8;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;

   // int8 saturation bounds on the rounded magnitude
   localparam logic [ACT_W-1:0] Q_MAX     = 32'd127;
   localparam logic [ACT_W-1:0] Q_MIN_MAG = 32'd128;
   localparam logic signed [QACT_W-1:0] Q_POS_SAT = 8'sd127;
   localparam logic signed [QACT_W-1:0] Q_NEG_SAT = -8'sd128;

   // quantised activation handed from the quantiser to the lanes
   typedef struct packed {
      logic                     valid;
      logic                     last;
      logic signed [QACT_W-1:0] act_q;
      logic [WPACK_W-1:0]       weights;
   } qnt_out_type;

endpackage

[rtl/igemv_quant.sv]
module igemv_quant
   import igemv_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic [ACT_W-1:0]   activation,
   input  logic [WPACK_W-1:0] weights,
   input  logic               last,
   input  logic [SCALE_W-1:0] scale,
   output qnt_out_type        q_out
);

   // stage 1: sign and magnitude
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_neg_ff;
   logic [ACT_W-1:0]   s1_mag_ff, s1_mag_in;
   logic [WPACK_W-1:0] s1_w_ff;
   logic               s1_last_ff;

   // stage 2: exact Q32.32 product
   logic               s2_valid_ff;
   logic               s2_neg_ff;
   logic [PROD_W-1:0]  s2_prod_ff, s2_prod_in;
   logic [WPACK_W-1:0] s2_w_ff;
   logic               s2_last_ff;

   // stage 3: rounded and clamped int8
   qnt_out_type        s3_ff, s3_in;

   logic [ACT_W-1:0]   whole;
   logic [ACT_W-1:0]   frac;
   logic               round_up;
   logic [ACT_W-1:0]   rounded;

   // magnitude of the most negative value wraps to itself, which is correct unsigned
   assign s1_mag_in   = activation[ACT_W-1] ? (~activation + 1'b1) : activation;
   assign s1_valid_in = in_valid;

   assign s2_prod_in = PROD_W'(s1_mag_ff) * PROD_W'(scale);

   // round to nearest, ties to even, then saturate on the magnitude
   always_comb begin
      whole    = s2_prod_ff[PROD_W-1:ACT_W];
      frac     = s2_prod_ff[ACT_W-1:0];
      round_up = frac[ACT_W-1] && ((frac[ACT_W-2:0] != '0) || whole[0]);
      rounded  = whole + ACT_W'(round_up);
      s3_in.valid   = s2_valid_ff;
      s3_in.last    = s2_last_ff;
      s3_in.weights = s2_w_ff;
      if (s2_neg_ff) begin
         if (rounded >= Q_MIN_MAG) begin
            s3_in.act_q = Q_NEG_SAT;
         end else begin
            s3_in.act_q = -$signed(rounded[QACT_W-1:0]);
         end
      end else begin
         if (rounded > Q_MAX) begin
            s3_in.act_q = Q_POS_SAT;
         end else begin
            s3_in.act_q = $signed(rounded[QACT_W-1:0]);
         end
      end
   end

   // valid bits of the pipeline and the output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_ff       <= s3_in;
      end
   end

   // payload of the pipeline
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_neg_ff     <= activation[ACT_W-1];
         s1_mag_ff     <= s1_mag_in;
         s1_w_ff       <= weights;
         s1_last_ff    <= last;
         s2_neg_ff     <= s1_neg_ff;
         s2_prod_ff    <= s2_prod_in;
         s2_w_ff       <= s1_w_ff;
         s2_last_ff    <= s1_last_ff;
      end
   end

   assign q_out = s3_ff;

endmodule

[rtl/igemv_lane.sv]
module igemv_lane
   import igemv_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  logic                       last,
   input  logic signed [QACT_W-1:0]   act_q,
   input  logic signed [WEIGHT_W-1:0] weight,
   output logic [ACC_W-1:0]           sum
);

   localparam int MUL_W = QACT_W + WEIGHT_W;

   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic signed [MUL_W-1:0] prod;

   // int8 by int8 product, sign extended into the wrapping accumulator
   assign prod   = act_q * weight;
   assign sum    = acc_ff + {{(ACC_W-MUL_W){prod[MUL_W-1]}}, prod};
   assign acc_in = last ? '0 : sum;

   // accumulator, cleared once its sum has been handed on
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (enable) begin
         acc_ff <= acc_in;
      end
   end

endmodule

[rtl/int8_quantized_gemv_lanes_top.sv]
// a tlast item runs through the sign, product and rounding stages, then the result register
// throughput: one item per cycle unless stalled, via the pipelined 32x32 quantiser multiplier
// the pipe stalls only while a finished result waits and another tlast item reaches the lanes
// reset clears accumulators, pipeline and result valid, and loads the scale with 1.0
module int8_quantized_gemv_lanes_top
   import igemv_pkg::*;
#(
   parameter int LANES = LANES_DEFAULT
)(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // activation [31:0], weights_packed [95:32]
   input  logic [ACT_W+WPACK_W-1:0]     req_tdata,
   input  logic                         req_tlast,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // acc_lane0 [31:0] up to acc_lane7 [255:224]
   output logic [ACC_W*OUT_LANES-1:0]   rsp_tdata,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [SCALE_W-1:0]           csr_data
);

   logic [SCALE_W-1:0]               scale_ff;
   logic                             pipe_adv;
   qnt_out_type                      q_st;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [ACC_W*OUT_LANES-1:0]       rsp_data_ff, rsp_data_in;
   logic                             load_out;
   logic signed [WEIGHT_W-1:0]       lane_w   [LANES];
   logic [ACC_W-1:0]                 lane_sum [LANES];

   // configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         scale_ff <= csr_data;
      end
   end

   // whole pipe holds while a finished result waits and another one is due
   assign pipe_adv   = !(q_st.valid && q_st.last && rsp_valid_ff && !rsp_tready);
   assign req_tready = pipe_adv;

   igemv_quant u_quant (
      .clock      (clock),
      .reset      (reset),
      .adv        (pipe_adv),
      .in_valid   (req_tvalid),
      .activation (req_tdata[ACT_W-1:0]),
      .weights    (req_tdata[ACT_W+WPACK_W-1:ACT_W]),
      .last       (req_tlast),
      .scale      (scale_ff),
      .q_out      (q_st)
   );

   // lanes, those past the packed weights see weight zero
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      if (i < WEIGHT_LANES) begin : g_w
         assign lane_w[i] = $signed(q_st.weights[WEIGHT_W*i +: WEIGHT_W]);
      end else begin : g_nw
         assign lane_w[i] = '0;
      end

      igemv_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .enable (pipe_adv && q_st.valid),
         .last   (q_st.last),
         .act_q  (q_st.act_q),
         .weight (lane_w[i]),
         .sum    (lane_sum[i])
      );
   end

   // merge lane sums into the result word
   for (genvar j = 0; j < OUT_LANES; j++) begin : g_merge
      if (j < LANES) begin : g_used
         assign rsp_data_in[ACC_W*j +: ACC_W] = lane_sum[j];
      end else begin : g_unused
         assign rsp_data_in[ACC_W*j +: ACC_W] = '0;
      end
   end

   assign load_out     = pipe_adv && q_st.valid && q_st.last;
   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp_tready);

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !load_out)
      else $error("result overwritten while waiting");

   // a new result only follows a last item leaving the lanes
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(q_st.valid && q_st.last && pipe_adv))
      else $error("result without a last item");

   // a stalled pipe means a result is waiting and another last item is due
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_valid_ff && q_st.valid && q_st.last)
      else $error("pipe stalled without cause");
`endif

endmodule
